@@ design/stcw_pkg.sv @@
`default_nettype none
package stcw_pkg;

  localparam int unsigned WORD_COUNT = 64;
  localparam int unsigned ADDR_W     = $clog2(WORD_COUNT);
  localparam logic [31:0] IDENTITY_VALUE = 32'h0000_0000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef logic [ADDR_W-1:0] addr_t;

  // Register word indexes (byte offset / 4)
  localparam addr_t W_CLC     = addr_t'(0);
  localparam addr_t W_ID      = addr_t'(2);
  localparam addr_t W_TIM0    = addr_t'(4);
  localparam addr_t W_TIM6    = addr_t'(10);
  localparam addr_t W_CAP     = addr_t'(11);
  localparam addr_t W_CMP0    = addr_t'(12);
  localparam addr_t W_CMP1    = addr_t'(13);
  localparam addr_t W_CMCON   = addr_t'(14);
  localparam addr_t W_ICR     = addr_t'(15);
  localparam addr_t W_ISCR    = addr_t'(16);
  localparam addr_t W_TIM0SV  = addr_t'(8'h50 / 4);
  localparam addr_t W_CAPSV   = addr_t'(8'h50 / 4 + 1);
  localparam addr_t W_OCS     = addr_t'(8'hE8 / 4);
  localparam addr_t W_KRSTCLR = addr_t'(8'hE8 / 4 + 1);
  localparam addr_t W_KRST1   = addr_t'(8'hE8 / 4 + 2);
  localparam addr_t W_KRST0   = addr_t'(8'hE8 / 4 + 3);
  localparam addr_t W_ACCEN1  = addr_t'(8'hE8 / 4 + 4);
  localparam addr_t W_ACCEN0  = addr_t'(8'hE8 / 4 + 5);

  // ICR and ISCR bit positions
  localparam int unsigned ICR_CMP0EN   = 0;
  localparam int unsigned ICR_CMP0IR   = 1;
  localparam int unsigned ICR_CMP1IR   = 5;
  localparam int unsigned ISCR_CMP0IRR = 0;
  localparam int unsigned ISCR_CMP0IRS = 1;
  localparam int unsigned ISCR_CMP1IRR = 2;
  localparam int unsigned ISCR_CMP1IRS = 3;

  typedef struct packed {
    logic [1:0]  operation;
    addr_t       word_address;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        compare_irq;
  } out_item_t;

endpackage
`default_nettype wire

@@ design/stcw_in_if.sv @@
`default_nettype none
interface stcw_in_if;
  import stcw_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/stcw_out_if.sv @@
`default_nettype none
interface stcw_out_if;
  import stcw_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/system_timer_compare_window_unit.sv @@
// The result of an item is registered and is on the output in the cycle after it is accepted.
// Throughput: one item per cycle while the output is taken; the counter, register words and compare window
// all update at the clock edge that loads the result register.
// The result register frees as it is taken, so input and output may both move each cycle.
// Reset (synchronous, rst_n low): counter and register words clear, ID loads
// the identity value, output goes empty.
`default_nettype none
module system_timer_compare_window_unit (
  input  wire          clk,
  input  wire          rst_n,
  stcw_in_if.sink      in_ch,
  stcw_out_if.source   out_ch
);
  import stcw_pkg::*;

  logic [63:0] count_r, count_nxt;
  logic [31:0] clc_r, clc_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] cap_r, cap_nxt;
  logic [31:0] cmp0_r, cmp0_nxt;
  logic [31:0] cmp1_r, cmp1_nxt;
  logic [31:0] cmcon_r, cmcon_nxt;
  logic [31:0] icr_r, icr_nxt;
  logic [31:0] ocs_r, ocs_nxt;
  logic [31:0] krstclr_r, krstclr_nxt;
  logic [31:0] krst1_r, krst1_nxt;
  logic [31:0] krst0_r, krst0_nxt;
  logic [31:0] accen1_r, accen1_nxt;
  logic [31:0] accen0_r, accen0_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic        accept;
  logic [63:0] count_inc;
  logic [4:0]  win_start;
  logic [5:0]  win_bits;
  logic [5:0]  win_top;
  logic [63:0] full_mask;
  logic [63:0] win_mask;
  logic [63:0] target;
  logic        match;
  logic [2:0]  tim_idx;
  logic [63:0] tim_shifted;
  logic [31:0] rd;
  logic        irq;
  addr_t       addr;
  logic [31:0] wdata;

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign addr  = in_ch.data.word_address;
  assign wdata = in_ch.data.write_data;

  // Compare window: bits below start must be zero, window must equal low CMP0 bits.
  // start + size + 1 never exceeds 63, so one mask covers both checks.
  assign count_inc = count_r + 64'd1;
  assign win_start = cmcon_r[12:8];
  assign win_bits  = {1'b0, cmcon_r[4:0]} + 6'd1;
  assign win_top   = {1'b0, win_start} + win_bits;
  assign full_mask = ~({64{1'b1}} << win_top);
  assign win_mask  = ~({64{1'b1}} << win_bits);
  assign target    = ({32'd0, cmp0_r} & win_mask) << win_start;
  assign match     = (count_inc & full_mask) == target;

  assign tim_idx     = 3'(addr - W_TIM0);
  assign tim_shifted = count_r >> {tim_idx, 2'b00};

  always_comb begin
    count_nxt   = count_r;
    clc_nxt     = clc_r;
    id_nxt      = id_r;
    cap_nxt     = cap_r;
    cmp0_nxt    = cmp0_r;
    cmp1_nxt    = cmp1_r;
    cmcon_nxt   = cmcon_r;
    icr_nxt     = icr_r;
    ocs_nxt     = ocs_r;
    krstclr_nxt = krstclr_r;
    krst1_nxt   = krst1_r;
    krst0_nxt   = krst0_r;
    accen1_nxt  = accen1_r;
    accen0_nxt  = accen0_r;
    rd          = 32'd0;
    irq         = 1'b0;
    if (accept) begin
      case (op_t'(in_ch.data.operation))
        OP_TICK: begin
          count_nxt = count_inc;
          if (match) begin
            icr_nxt[ICR_CMP0IR] = 1'b1;
            irq = icr_r[ICR_CMP0EN];
          end
        end
        OP_READ: begin
          // Timer reads snapshot the upper half of the counter
          if (addr inside {[W_TIM0:W_TIM6], W_TIM0SV}) begin
            cap_nxt = count_r[63:32];
          end
          case (addr)
            W_TIM0SV:           rd = count_r[31:0];
            W_CAP, W_CAPSV:     rd = cap_r;
            W_CLC:              rd = clc_r;
            W_ID:               rd = id_r;
            W_CMP0:             rd = cmp0_r;
            W_CMP1:             rd = cmp1_r;
            W_CMCON:            rd = cmcon_r;
            W_ICR:              rd = icr_r;
            W_OCS:              rd = ocs_r;
            W_KRSTCLR:          rd = krstclr_r;
            W_KRST1:            rd = krst1_r;
            W_KRST0:            rd = krst0_r;
            W_ACCEN1:           rd = accen1_r;
            W_ACCEN0:           rd = accen0_r;
            default: begin
              if (addr inside {[W_TIM0:W_TIM6]}) begin
                rd = tim_shifted[31:0];
              end
            end
          endcase
        end
        OP_WRITE: begin
          case (addr)
            W_ISCR: begin
              // Clear first, then set
              if (wdata[ISCR_CMP0IRR]) icr_nxt[ICR_CMP0IR] = 1'b0;
              if (wdata[ISCR_CMP1IRR]) icr_nxt[ICR_CMP1IR] = 1'b0;
              if (wdata[ISCR_CMP0IRS]) icr_nxt[ICR_CMP0IR] = 1'b1;
              if (wdata[ISCR_CMP1IRS]) icr_nxt[ICR_CMP1IR] = 1'b1;
            end
            W_CLC:     clc_nxt     = wdata;
            W_ID:      id_nxt      = wdata;
            W_CAP:     cap_nxt     = wdata;
            W_CMP0:    cmp0_nxt    = wdata;
            W_CMP1:    cmp1_nxt    = wdata;
            W_CMCON:   cmcon_nxt   = wdata;
            W_ICR:     icr_nxt     = wdata;
            W_OCS:     ocs_nxt     = wdata;
            W_KRSTCLR: krstclr_nxt = wdata;
            W_KRST1:   krst1_nxt   = wdata;
            W_KRST0:   krst0_nxt   = wdata;
            W_ACCEN1:  accen1_nxt  = wdata;
            W_ACCEN0:  accen0_nxt  = wdata;
            // TIMn, TIM0SV and CAPSV words are never read back as stored: drop
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_data_nxt.read_data   = rd;
      out_data_nxt.compare_irq = irq;
      out_valid_nxt            = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= 64'd0;
      clc_r       <= 32'd0;
      id_r        <= IDENTITY_VALUE;
      cap_r       <= 32'd0;
      cmp0_r      <= 32'd0;
      cmp1_r      <= 32'd0;
      cmcon_r     <= 32'd0;
      icr_r       <= 32'd0;
      ocs_r       <= 32'd0;
      krstclr_r   <= 32'd0;
      krst1_r     <= 32'd0;
      krst0_r     <= 32'd0;
      accen1_r    <= 32'd0;
      accen0_r    <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      clc_r       <= clc_nxt;
      id_r        <= id_nxt;
      cap_r       <= cap_nxt;
      cmp0_r      <= cmp0_nxt;
      cmp1_r      <= cmp1_nxt;
      cmcon_r     <= cmcon_nxt;
      icr_r       <= icr_nxt;
      ocs_r       <= ocs_nxt;
      krstclr_r   <= krstclr_nxt;
      krst1_r     <= krst1_nxt;
      krst0_r     <= krst0_nxt;
      accen1_r    <= accen1_nxt;
      accen0_r    <= accen0_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_count_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.operation == OP_TICK) |=> count_r == $past(count_r) + 64'd1)
    else $error("counter did not advance on tick");

  a_irq_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.operation != OP_TICK) |=> !out_data_r.compare_irq)
    else $error("interrupt raised by a non-tick item");

  a_irq_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.compare_irq) |-> (icr_r[ICR_CMP0IR] && icr_r[ICR_CMP0EN]))
    else $error("interrupt without flag and enable set");

  a_cap_snapshot: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.data.operation == OP_READ && addr == W_TIM0SV)
      |=> cap_r == $past(count_r[63:32]))
    else $error("capture missed on TIM0SV read");

endmodule
`default_nettype wire
